@@ rtl/bpah_pkg.sv @@
// ----------------------------------------------------------------------------
// bpah_pkg
// Shared constants, codes and types of the byte peak / histogram core.
// ----------------------------------------------------------------------------
package bpah_pkg;

   // component peak store depth and histogram counter width
   localparam int MAX_COMPONENTS = 32;
   localparam int COUNT_BITS     = 32;

   localparam int COMP_AW   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
   localparam int FIN_W     = COMP_AW + 1;
   localparam int HIST_DEPTH = 256;
   localparam int HIST_AW   = 8;

   localparam logic [7:0]  ZERO_LEVEL = 8'd128;
   localparam logic [12:0] LEN_MAX    = 13'd4096;
   localparam logic [12:0] LEN_COMP   = 13'(MAX_COMPONENTS);

   // input operation codes
   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_FINISH = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_VECTOR    = 2'd0,
      KIND_COMPONENT = 2'd1,
      KIND_OVERALL   = 2'd2,
      KIND_HIST      = 2'd3
   } kind_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_MODE = 1'b0,
      CSR_SCAN = 1'b1
   } csr_idx_type;

   // control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_HREAD,
      ST_FIN_EMIT,
      ST_FIN_TOTAL
   } state_type;

   // histogram store command
   typedef struct packed {
      logic               rd_en;
      logic               inc_en;
      logic               clr;
      logic [HIST_AW-1:0] addr;
   } hist_cmd_type;

   // component peak store command
   typedef struct packed {
      logic               rd_en;
      logic               upd_en;
      logic               clr;
      logic [COMP_AW-1:0] addr;
   } peak_cmd_type;

endpackage

@@ rtl/bpah_ram.sv @@
// ----------------------------------------------------------------------------
// bpah_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpah_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bpah_hist.sv @@
// ----------------------------------------------------------------------------
// bpah_hist
// 256-bin histogram store: RAM plus per-bin valid bits, saturating
// read-modify-write increment on the last bin read.
// ----------------------------------------------------------------------------
module bpah_hist (
   input  logic                              clock,
   input  logic                              reset,
   input  bpah_pkg::hist_cmd_type            cmd,
   output logic [bpah_pkg::COUNT_BITS-1:0]   count
);

   logic [bpah_pkg::HIST_DEPTH-1:0]  valid_ff;
   logic [bpah_pkg::HIST_DEPTH-1:0]  valid_in;
   logic [bpah_pkg::HIST_AW-1:0]     addr_ff;
   logic [bpah_pkg::HIST_AW-1:0]     addr_in;
   logic                             rd_valid_ff;
   logic                             rd_valid_in;
   logic [bpah_pkg::COUNT_BITS-1:0]  ram_rd_data;
   logic [bpah_pkg::COUNT_BITS-1:0]  count_inc;

   bpah_ram #(
      .WIDTH (bpah_pkg::COUNT_BITS),
      .DEPTH (bpah_pkg::HIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.inc_en),
      .wr_addr (addr_ff),
      .wr_data (count_inc),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.addr),
      .rd_data (ram_rd_data)
   );

   // a bin never written since clear reads as zero
   assign count = rd_valid_ff ? ram_rd_data : '0;

   // saturating increment
   assign count_inc = (&count) ? count : count + 1'b1;

   // valid bits and read address tracking
   always_comb begin
      valid_in    = valid_ff;
      addr_in     = addr_ff;
      rd_valid_in = rd_valid_ff;
      if (cmd.clr) begin
         valid_in = '0;
      end else if (cmd.inc_en) begin
         valid_in[addr_ff] = 1'b1;
      end
      if (cmd.rd_en) begin
         addr_in     = cmd.addr;
         rd_valid_in = valid_ff[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

endmodule

@@ rtl/bpah_peaks.sv @@
// ----------------------------------------------------------------------------
// bpah_peaks
// Per-component peak store: RAM plus per-entry valid bits, running max
// update of the last entry read.
// ----------------------------------------------------------------------------
module bpah_peaks (
   input  logic                          clock,
   input  logic                          reset,
   input  bpah_pkg::peak_cmd_type        cmd,
   input  logic [7:0]                    upd_value,
   output logic [7:0]                    peak
);

   logic [bpah_pkg::MAX_COMPONENTS-1:0] valid_ff;
   logic [bpah_pkg::MAX_COMPONENTS-1:0] valid_in;
   logic [bpah_pkg::COMP_AW-1:0]        addr_ff;
   logic [bpah_pkg::COMP_AW-1:0]        addr_in;
   logic                                rd_valid_ff;
   logic                                rd_valid_in;
   logic [7:0]                          ram_rd_data;
   logic [7:0]                          peak_max;

   bpah_ram #(
      .WIDTH (8),
      .DEPTH (bpah_pkg::MAX_COMPONENTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.upd_en),
      .wr_addr (addr_ff),
      .wr_data (peak_max),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.addr),
      .rd_data (ram_rd_data)
   );

   assign peak     = rd_valid_ff ? ram_rd_data : 8'd0;
   assign peak_max = (upd_value > peak) ? upd_value : peak;

   // valid bits and read address tracking
   always_comb begin
      valid_in    = valid_ff;
      addr_in     = addr_ff;
      rd_valid_in = rd_valid_ff;
      if (cmd.clr) begin
         valid_in = '0;
      end else if (cmd.upd_en) begin
         valid_in[addr_ff] = 1'b1;
      end
      if (cmd.rd_en) begin
         addr_in     = cmd.addr;
         rd_valid_in = valid_ff[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

endmodule

@@ rtl/byte_peak_abs_and_histogram_core.sv @@
// ----------------------------------------------------------------------------
// byte_peak_abs_and_histogram_core
// Peak |x-128| per vector or per component, overall peak and a saturating
// 256-bin histogram of offset-binary byte samples.
// ----------------------------------------------------------------------------
//  channel   ports                                        direction
//  req       req_valid/ready, op, sample, bin_index      in
//  rsp       rsp_valid/ready, kind, position, peak,       out
//            bin_count, last
//  csr       csr_valid/ready, csr_index, csr_data         in (write only)
//
//  Sample and bin read first read the histogram memory, then write back or
//  show the result. Clear completes as the request is taken.
//  Finish emits the overall peak; in component mode it first emits one beat
//  per vector position, one component peak memory read per emitted beat.
//  Reset is synchronous, empties all stores at once through valid bits.
//  A held result beat stalls only steps that must emit a new one.
// ----------------------------------------------------------------------------
module byte_peak_abs_and_histogram_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_sample,
   input  logic [7:0]  req_bin_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_position,
   output logic [7:0]  rsp_peak,
   output logic [31:0] rsp_bin_count,
   output logic        rsp_last,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_data
);

   bpah_pkg::state_type              state_ff, state_in;
   bpah_pkg::op_type                 op_ff, op_in, req_op_code;
   logic [7:0]                       sample_ff, sample_in;
   logic [7:0]                       bin_ff, bin_in;

   logic                             mode_ff, mode_in;
   logic [12:0]                      scan_ff, scan_in;

   logic [7:0]                       vpeak_ff, vpeak_in;
   logic [7:0]                       opeak_ff, opeak_in;
   logic [11:0]                      pos_ff, pos_in;
   logic [15:0]                      vnum_ff, vnum_in;
   logic [bpah_pkg::FIN_W-1:0]       fin_idx_ff, fin_idx_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   bpah_pkg::kind_type               rsp_kind_ff, rsp_kind_in;
   logic [15:0]                      rsp_position_ff, rsp_position_in;
   logic [7:0]                       rsp_peak_ff, rsp_peak_in;
   logic [31:0]                      rsp_bin_count_ff, rsp_bin_count_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             load_out;

   bpah_pkg::hist_cmd_type           hist_cmd;
   bpah_pkg::peak_cmd_type           peak_cmd;
   logic [bpah_pkg::COUNT_BITS-1:0]  hist_count;
   logic [63:0]                      hist_count_wide;
   logic [7:0]                       comp_peak;

   logic                             req_fire;
   logic                             out_free;
   logic [12:0]                      vec_len;
   logic [12:0]                      len_clamp;
   logic [11:0]                      pos_eff;
   logic [12:0]                      pos_inc;
   logic                             wrap;
   logic                             need_emit;
   logic [7:0]                       abs_val;
   logic [7:0]                       vpeak_new;
   logic [12:0]                      fin_next;
   logic                             fin_more;

   // handshakes
   assign req_ready   = (state_ff == bpah_pkg::ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign req_op_code = bpah_pkg::op_type'(req_op);
   assign csr_ready   = 1'b1;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // effective vector length
   always_comb begin
      if (scan_ff == 13'd0) begin
         len_clamp = 13'd1;
      end else if (scan_ff > bpah_pkg::LEN_MAX) begin
         len_clamp = bpah_pkg::LEN_MAX;
      end else begin
         len_clamp = scan_ff;
      end
      if (mode_ff && (len_clamp > bpah_pkg::LEN_COMP)) begin
         vec_len = bpah_pkg::LEN_COMP;
      end else begin
         vec_len = len_clamp;
      end
   end

   // position within the vector, wrapped if the length shrank
   assign pos_eff   = ({1'b0, pos_ff} >= vec_len) ? 12'd0 : pos_ff;
   assign pos_inc   = {1'b0, pos_eff} + 13'd1;
   assign wrap      = (pos_inc >= vec_len);
   assign need_emit = !mode_ff && wrap;

   // |sample - 128|
   assign abs_val   = (sample_ff >= bpah_pkg::ZERO_LEVEL) ?
                      sample_ff - bpah_pkg::ZERO_LEVEL :
                      bpah_pkg::ZERO_LEVEL - sample_ff;
   assign vpeak_new = (abs_val > vpeak_ff) ? abs_val : vpeak_ff;

   // finish walk over component peaks
   assign fin_next = 13'(fin_idx_ff) + 13'd1;
   assign fin_more = (fin_next < vec_len);

   // histogram count widened, clipped to the result width at bin read
   assign hist_count_wide = 64'(hist_count);

   // stores
   bpah_hist u_hist (
      .clock (clock),
      .reset (reset),
      .cmd   (hist_cmd),
      .count (hist_count)
   );

   bpah_peaks u_peaks (
      .clock     (clock),
      .reset     (reset),
      .cmd       (peak_cmd),
      .upd_value (abs_val),
      .peak      (comp_peak)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpah_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_op_code)
                  bpah_pkg::OP_SAMPLE: state_in = bpah_pkg::ST_SAMPLE;
                  bpah_pkg::OP_READ:   state_in = bpah_pkg::ST_HREAD;
                  bpah_pkg::OP_FINISH: state_in = mode_ff ? bpah_pkg::ST_FIN_EMIT :
                                                            bpah_pkg::ST_FIN_TOTAL;
                  bpah_pkg::OP_CLEAR:  state_in = bpah_pkg::ST_IDLE;
                  default:             state_in = bpah_pkg::ST_IDLE;
               endcase
            end
         end
         bpah_pkg::ST_SAMPLE: begin
            if (!need_emit || out_free) begin
               state_in = bpah_pkg::ST_IDLE;
            end
         end
         bpah_pkg::ST_HREAD: begin
            if (out_free) begin
               state_in = bpah_pkg::ST_IDLE;
            end
         end
         bpah_pkg::ST_FIN_EMIT: begin
            if (out_free && !fin_more) begin
               state_in = bpah_pkg::ST_FIN_TOTAL;
            end
         end
         bpah_pkg::ST_FIN_TOTAL: begin
            if (out_free) begin
               state_in = bpah_pkg::ST_IDLE;
            end
         end
         default: state_in = bpah_pkg::ST_IDLE;
      endcase
   end

   // datapath and store commands
   always_comb begin
      op_in            = op_ff;
      sample_in        = sample_ff;
      bin_in           = bin_ff;
      vpeak_in         = vpeak_ff;
      opeak_in         = opeak_ff;
      pos_in           = pos_ff;
      vnum_in          = vnum_ff;
      fin_idx_in       = fin_idx_ff;
      hist_cmd         = '0;
      peak_cmd         = '0;
      load_out         = 1'b0;
      rsp_kind_in      = rsp_kind_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_peak_in      = rsp_peak_ff;
      rsp_bin_count_in = rsp_bin_count_ff;
      rsp_last_in      = rsp_last_ff;

      unique case (state_ff)
         bpah_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_op_code;
               sample_in = req_sample;
               bin_in    = req_bin_index;
               unique case (req_op_code)
                  bpah_pkg::OP_SAMPLE: begin
                     hist_cmd.rd_en = 1'b1;
                     hist_cmd.addr  = req_sample;
                     peak_cmd.rd_en = mode_ff;
                     peak_cmd.addr  = pos_eff[bpah_pkg::COMP_AW-1:0];
                  end
                  bpah_pkg::OP_READ: begin
                     hist_cmd.rd_en = 1'b1;
                     hist_cmd.addr  = req_bin_index;
                  end
                  bpah_pkg::OP_FINISH: begin
                     peak_cmd.rd_en = mode_ff;
                     peak_cmd.addr  = '0;
                     fin_idx_in     = '0;
                  end
                  bpah_pkg::OP_CLEAR: begin
                     hist_cmd.clr = 1'b1;
                     peak_cmd.clr = 1'b1;
                     vpeak_in     = 8'd0;
                     opeak_in     = 8'd0;
                     pos_in       = 12'd0;
                     vnum_in      = 16'd0;
                  end
                  default: ;
               endcase
            end
         end

         // write back histogram and peaks, maybe emit vector peak
         bpah_pkg::ST_SAMPLE: begin
            if (!need_emit || out_free) begin
               hist_cmd.inc_en = 1'b1;
               if (abs_val > opeak_ff) begin
                  opeak_in = abs_val;
               end
               pos_in = wrap ? 12'd0 : pos_inc[11:0];
               if (mode_ff) begin
                  peak_cmd.upd_en = 1'b1;
               end else if (wrap) begin
                  load_out         = 1'b1;
                  rsp_kind_in      = bpah_pkg::KIND_VECTOR;
                  rsp_position_in  = vnum_ff;
                  rsp_peak_in      = vpeak_new;
                  rsp_bin_count_in = 32'd0;
                  rsp_last_in      = 1'b1;
                  vpeak_in         = 8'd0;
                  vnum_in          = vnum_ff + 16'd1;
               end else begin
                  vpeak_in = vpeak_new;
               end
            end
         end

         bpah_pkg::ST_HREAD: begin
            if (out_free) begin
               load_out         = 1'b1;
               rsp_kind_in      = bpah_pkg::KIND_HIST;
               rsp_position_in  = 16'(bin_ff);
               rsp_peak_in      = 8'd0;
               rsp_bin_count_in = (|hist_count_wide[63:32]) ? 32'hFFFF_FFFF :
                                  hist_count_wide[31:0];
               rsp_last_in      = 1'b1;
            end
         end

         // one component peak per beat, next entry read meanwhile
         bpah_pkg::ST_FIN_EMIT: begin
            if (out_free) begin
               load_out         = 1'b1;
               rsp_kind_in      = bpah_pkg::KIND_COMPONENT;
               rsp_position_in  = 16'(fin_idx_ff);
               rsp_peak_in      = comp_peak;
               rsp_bin_count_in = 32'd0;
               rsp_last_in      = 1'b0;
               if (fin_more) begin
                  peak_cmd.rd_en = 1'b1;
                  peak_cmd.addr  = fin_next[bpah_pkg::COMP_AW-1:0];
                  fin_idx_in     = fin_next[bpah_pkg::FIN_W-1:0];
               end
            end
         end

         // overall peak, then all peaks start over
         bpah_pkg::ST_FIN_TOTAL: begin
            if (out_free) begin
               load_out         = 1'b1;
               rsp_kind_in      = bpah_pkg::KIND_OVERALL;
               rsp_position_in  = mode_ff ? 16'(vec_len) : vnum_ff;
               rsp_peak_in      = opeak_ff;
               rsp_bin_count_in = 32'd0;
               rsp_last_in      = 1'b1;
               peak_cmd.clr     = 1'b1;
               vpeak_in         = 8'd0;
               opeak_in         = 8'd0;
               pos_in           = 12'd0;
               vnum_in          = 16'd0;
            end
         end

         default: ;
      endcase
   end

   // configuration writes
   always_comb begin
      mode_in = mode_ff;
      scan_in = scan_ff;
      if (csr_valid && csr_ready) begin
         unique case (bpah_pkg::csr_idx_type'(csr_index))
            bpah_pkg::CSR_MODE: mode_in = csr_data[0];
            bpah_pkg::CSR_SCAN: scan_in = csr_data;
            default: ;
         endcase
      end
   end

   // result register
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpah_pkg::ST_IDLE;
         mode_ff      <= 1'b0;
         scan_ff      <= 13'd32;
         vpeak_ff     <= 8'd0;
         opeak_ff     <= 8'd0;
         pos_ff       <= 12'd0;
         vnum_ff      <= 16'd0;
         fin_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         scan_ff      <= scan_in;
         vpeak_ff     <= vpeak_in;
         opeak_ff     <= opeak_in;
         pos_ff       <= pos_in;
         vnum_ff      <= vnum_in;
         fin_idx_ff   <= fin_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      sample_ff        <= sample_in;
      bin_ff           <= bin_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_peak_ff      <= rsp_peak_in;
      rsp_bin_count_ff <= rsp_bin_count_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_peak      = rsp_peak_ff;
   assign rsp_bin_count = rsp_bin_count_ff;
   assign rsp_last      = rsp_last_ff;

   // checks
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (load_out && rsp_valid_ff) |-> rsp_ready)
      else $error("result beat overwritten before taken");

   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      (opeak_ff <= 8'd128) && (vpeak_ff <= 8'd128))
      else $error("peak above 128");

   a_fin_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpah_pkg::ST_FIN_EMIT) |-> (13'(fin_idx_ff) < vec_len))
      else $error("component walk beyond vector length");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op_code == bpah_pkg::OP_CLEAR)) |=>
      ((opeak_ff == 8'd0) && (vnum_ff == 16'd0) && (state_ff == bpah_pkg::ST_IDLE)))
      else $error("clear did not empty peaks");

   a_overall_last: assert property (@(posedge clock) disable iff (reset)
      (load_out && (rsp_kind_in == bpah_pkg::KIND_OVERALL)) |=>
      (rsp_last_ff && (state_ff == bpah_pkg::ST_IDLE) && (opeak_ff == 8'd0)))
      else $error("overall peak not closing finish");

   // op register is kept for debug visibility of the active operation
   a_op_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpah_pkg::ST_HREAD) |-> (op_ff == bpah_pkg::OP_READ))
      else $error("bin read state without read operation");

endmodule
